// ===== hw/rtl/jpds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jpds_pkg
// Types and constants shared by the joint servo front end, queue and back end.
// ----------------------------------------------------------------------------
package jpds_pkg;

    localparam int JOINT_W  = 5;
    localparam int ANGLE_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_HW_POS_GAIN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HW_VEL_GAIN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_INV_STEP    = 2'd2;

    localparam logic [CFG_W-1:0] HW_POS_GAIN_RST = 16'd5000;
    localparam logic [CFG_W-1:0] HW_VEL_GAIN_RST = 16'd100;
    localparam logic [CFG_W-1:0] INV_STEP_RST    = 16'd1000;

    // control modes
    localparam logic [1:0] MODE_POS     = 2'd0;
    localparam logic [1:0] MODE_POS_TRQ = 2'd1;
    localparam logic [1:0] MODE_POS_FF  = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // servo command bits
    localparam int CMD_ON_BIT  = 0;
    localparam int CMD_OFF_BIT = 1;

    // job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CFG_W-1:0] hw_pos_gain;
        logic [CFG_W-1:0] hw_vel_gain;
        logic [CFG_W-1:0] inv_step;
    } t_cfg;

    typedef struct packed {
        logic [JOINT_W-1:0]        joint;
        logic signed [ANGLE_W:0]   pos_err;   // qref - act
        logic signed [ANGLE_W+1:0] vel_err;   // change of qref minus change of act
        logic [ANGLE_W-1:0]        trq_ref;
        logic [GAIN_W-2:0]         pos_gain;  // clamped at zero
        logic [GAIN_W-2:0]         vel_gain;
        logic [GAIN_W-2:0]         trq_gain;
        logic                      active;
        logic                      ff_en;
        logic                      power_on;
    } t_job;

endpackage
`default_nettype wire

// ===== hw/rtl/joint_pd_servo_with_power_control_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// joint_pd_servo_with_power_control_top
// Joint PD position servo with torque feedforward and per-joint servo power.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  tick in   input      i_valid / o_ready          joint, angles, torque ref,
//                                                  command, flags, mode, gains
//  result    output     o_valid / i_ready          joint_out, drive_torque,
//                                                  servo_is_on
//  config    input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  the front end handles a tick in capture, state read and update, and stalls
//  in update while the job queue is full; the back end works a job through the
//  steps of its shared multiplier and pops it in its last step, one at a time
//  a two-entry job queue lets the front keep accepting while the back works
//  reset gives servo flags on, previous angles zero and default gains
//  a full result register stalls the back end only in its last step
// ----------------------------------------------------------------------------
module joint_pd_servo_with_power_control_top #(
    parameter int JOINT_COUNT = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [jpds_pkg::JOINT_W-1:0]   i_joint,
    input  wire logic [jpds_pkg::ANGLE_W-1:0]   i_measured_angle,
    input  wire logic [jpds_pkg::ANGLE_W-1:0]   i_reference_angle,
    input  wire logic [jpds_pkg::ANGLE_W-1:0]   i_reference_torque,
    input  wire logic [1:0]                     i_servo_command,
    input  wire logic                           i_joint_enabled,
    input  wire logic                           i_loopback_mode,
    input  wire logic [1:0]                     i_control_mode,
    input  wire logic [jpds_pkg::GAIN_W-1:0]    i_position_gain,
    input  wire logic [jpds_pkg::GAIN_W-1:0]    i_velocity_gain,
    input  wire logic [jpds_pkg::GAIN_W-1:0]    i_torque_gain,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [jpds_pkg::JOINT_W-1:0]        o_joint_out,
    output logic [jpds_pkg::ANGLE_W-1:0]        o_drive_torque,
    output logic                                o_servo_is_on,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [jpds_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [jpds_pkg::CFG_W-1:0]     i_cfg_data
);
    import jpds_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job q_job;
    logic push;
    logic q_full;
    logic q_nempty;
    logic pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hw_pos_gain <= HW_POS_GAIN_RST;
            r_cfg.hw_vel_gain <= HW_VEL_GAIN_RST;
            r_cfg.inv_step    <= INV_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HW_POS_GAIN: r_cfg.hw_pos_gain <= i_cfg_data;
                CFG_HW_VEL_GAIN: r_cfg.hw_vel_gain <= i_cfg_data;
                CFG_INV_STEP:    r_cfg.inv_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    jpds_front #(
        .JOINT_COUNT(JOINT_COUNT)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_joint            (i_joint),
        .i_measured_angle   (i_measured_angle),
        .i_reference_angle  (i_reference_angle),
        .i_reference_torque (i_reference_torque),
        .i_servo_command    (i_servo_command),
        .i_joint_enabled    (i_joint_enabled),
        .i_loopback_mode    (i_loopback_mode),
        .i_control_mode     (i_control_mode),
        .i_position_gain    (i_position_gain),
        .i_velocity_gain    (i_velocity_gain),
        .i_torque_gain      (i_torque_gain),
        .o_push             (push),
        .o_job              (front_job),
        .i_q_full           (q_full)
    );

    jpds_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_job),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_nempty (q_nempty),
        .o_data   (q_job)
    );

    jpds_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job_valid    (q_nempty),
        .i_job          (q_job),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_joint_out    (o_joint_out),
        .o_drive_torque (o_drive_torque),
        .o_servo_is_on  (o_servo_is_on)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/jpds_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jpds_queue
// Small job queue that decouples the classifying front end from the back end.
// ----------------------------------------------------------------------------
module jpds_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jpds_pkg::t_job i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_nempty,
    output jpds_pkg::t_job     o_data
);
    import jpds_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full   = (r_count == QCNT_W'(QDEPTH));
    assign o_nempty = (r_count != '0);
    assign o_data   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("job queue read while empty");

endmodule
`default_nettype wire

// ===== hw/rtl/jpds_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jpds_front
// Accepts servo ticks, updates per-joint servo flags and previous angles,
// and hands the error terms to the job queue.
// ----------------------------------------------------------------------------
module jpds_front #(
    parameter int JOINT_COUNT = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [jpds_pkg::JOINT_W-1:0]   i_joint,
    input  wire logic [jpds_pkg::ANGLE_W-1:0]   i_measured_angle,
    input  wire logic [jpds_pkg::ANGLE_W-1:0]   i_reference_angle,
    input  wire logic [jpds_pkg::ANGLE_W-1:0]   i_reference_torque,
    input  wire logic [1:0]                     i_servo_command,
    input  wire logic                           i_joint_enabled,
    input  wire logic                           i_loopback_mode,
    input  wire logic [1:0]                     i_control_mode,
    input  wire logic [jpds_pkg::GAIN_W-1:0]    i_position_gain,
    input  wire logic [jpds_pkg::GAIN_W-1:0]    i_velocity_gain,
    input  wire logic [jpds_pkg::GAIN_W-1:0]    i_torque_gain,
    output logic                                o_push,
    output jpds_pkg::t_job                      o_job,
    input  wire logic                           i_q_full
);
    import jpds_pkg::*;

    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int EXT_W = (IDX_W > JOINT_W) ? IDX_W : JOINT_W;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_READ = 2'd1;
    localparam logic [1:0] F_CALC = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;

    logic [JOINT_W-1:0]     r_joint;
    logic [ANGLE_W-1:0]     r_act;
    logic [ANGLE_W-1:0]     r_ref;
    logic [ANGLE_W-1:0]     r_rtq;
    logic [1:0]             r_cmd;
    logic                   r_en;
    logic                   r_loop;
    logic [1:0]             r_mode;
    logic [GAIN_W-1:0]      r_pg;
    logic [GAIN_W-1:0]      r_vg;
    logic [GAIN_W-1:0]      r_tg;

    logic [ANGLE_W-1:0]     ref_mem  [JOINT_COUNT];
    logic [ANGLE_W-1:0]     meas_mem [JOINT_COUNT];
    logic [ANGLE_W-1:0]     r_rd_ref;
    logic [ANGLE_W-1:0]     r_rd_meas;
    logic [JOINT_COUNT-1:0] r_vld;
    logic [JOINT_COUNT-1:0] r_flags;

    logic [EXT_W-1:0]       joint_ext;
    logic [IDX_W-1:0]       idx;
    logic                   in_range;
    logic                   old_flag;
    logic                   new_flag;
    logic [ANGLE_W-1:0]     prev_ref;
    logic [ANGLE_W-1:0]     prev_meas;
    logic [ANGLE_W-1:0]     qref;
    logic signed [ANGLE_W+1:0] d_ref;
    logic signed [ANGLE_W+1:0] d_act;
    logic                   wr_en;

    assign joint_ext = EXT_W'(r_joint);
    assign idx       = joint_ext[IDX_W-1:0];
    assign in_range  = (32'(r_joint) < 32'(JOINT_COUNT));
    assign o_ready   = (r_state == F_IDLE);

    always_comb begin
        old_flag  = r_flags[idx];
        new_flag  = old_flag;
        if (r_cmd[CMD_OFF_BIT]) begin
            new_flag = 1'b0;
        end else if (r_cmd[CMD_ON_BIT] && r_en) begin
            new_flag = 1'b1;
        end
        prev_ref  = r_vld[idx] ? r_rd_ref  : '0;
        prev_meas = r_vld[idx] ? r_rd_meas : '0;
        // loopback tracks the last measured angle
        qref      = r_loop ? prev_meas : r_ref;
        d_ref     = {{2{qref[ANGLE_W-1]}}, qref} - {{2{prev_ref[ANGLE_W-1]}}, prev_ref};
        d_act     = {{2{r_act[ANGLE_W-1]}}, r_act} - {{2{prev_meas[ANGLE_W-1]}}, prev_meas};

        o_job.joint      = r_joint;
        o_job.pos_err    = {qref[ANGLE_W-1], qref} - {r_act[ANGLE_W-1], r_act};
        o_job.vel_err    = d_ref - d_act;
        o_job.trq_ref    = r_rtq;
        o_job.pos_gain   = r_pg[GAIN_W-1] ? '0 : r_pg[GAIN_W-2:0];
        o_job.vel_gain   = r_vg[GAIN_W-1] ? '0 : r_vg[GAIN_W-2:0];
        o_job.trq_gain   = r_tg[GAIN_W-1] ? '0 : r_tg[GAIN_W-2:0];
        o_job.active     = in_range && new_flag && !r_loop && (r_mode != MODE_NONE);
        o_job.ff_en      = (r_mode == MODE_POS_TRQ) || (r_mode == MODE_POS_FF);
        o_job.power_on   = in_range && new_flag;
    end

    assign o_push = (r_state == F_CALC) && !i_q_full;
    assign wr_en  = o_push && in_range;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_READ;
                end
            end
            F_READ: n_state = F_CALC;
            F_CALC: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_vld   <= '0;
            r_flags <= '1;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_vld[idx]   <= 1'b1;
                r_flags[idx] <= new_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_joint <= i_joint;
            r_act   <= i_measured_angle;
            r_ref   <= i_reference_angle;
            r_rtq   <= i_reference_torque;
            r_cmd   <= i_servo_command;
            r_en    <= i_joint_enabled;
            r_loop  <= i_loopback_mode;
            r_mode  <= i_control_mode;
            r_pg    <= i_position_gain;
            r_vg    <= i_velocity_gain;
            r_tg    <= i_torque_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ref_mem[idx]  <= qref;
            meas_mem[idx] <= r_act;
        end
        if (r_state == F_READ) begin
            r_rd_ref  <= ref_mem[idx];
            r_rd_meas <= meas_mem[idx];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/jpds_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jpds_back
// Computes the saturated PD plus feedforward torque of one job with a single
// shared multiplier over eight steps, and holds the result register.
// ----------------------------------------------------------------------------
module jpds_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire jpds_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_job_valid,
    input  wire jpds_pkg::t_job                 i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [jpds_pkg::JOINT_W-1:0]        o_joint_out,
    output logic [jpds_pkg::ANGLE_W-1:0]        o_drive_torque,
    output logic                                o_servo_is_on
);
    import jpds_pkg::*;

    localparam int A_W    = 35;
    localparam int B_W    = 33;
    localparam int P_W    = A_W + B_W;
    localparam int ACC_W  = 76;
    localparam int K_W    = 31;
    localparam int RATE_W = 50;
    localparam int RLO_W  = 25;

    localparam logic [2:0] ST_KP   = 3'd0;
    localparam logic [2:0] ST_KD   = 3'd1;
    localparam logic [2:0] ST_RATE = 3'd2;
    localparam logic [2:0] ST_P    = 3'd3;
    localparam logic [2:0] ST_DLO  = 3'd4;
    localparam logic [2:0] ST_DHI  = 3'd5;
    localparam logic [2:0] ST_FF   = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]               r_step;
    logic [2:0]               n_step;
    logic signed [A_W-1:0]    a_op;
    logic signed [B_W-1:0]    b_op;
    logic signed [P_W-1:0]    r_prod;
    logic [K_W-1:0]           r_kp;
    logic [K_W-1:0]           r_kd;
    logic [RATE_W-1:0]        r_rate;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         n_acc;
    logic [ACC_W-1:0]         prod_shr;
    logic [ACC_W-1:0]         prod_hi;
    logic [ACC_W-1:0]         final_sum;
    logic [ANGLE_W-1:0]       sat_sum;
    logic                     out_free;

    logic                     r_out_valid;
    logic [JOINT_W-1:0]       r_out_joint;
    logic [ANGLE_W-1:0]       r_out_torque;
    logic                     r_out_servo;

    // shared multiplier operand select
    always_comb begin
        a_op = '0;
        b_op = '0;
        unique case (r_step)
            ST_KP: begin
                a_op = {20'b0, i_job.pos_gain};
                b_op = {17'b0, i_cfg.hw_pos_gain};
            end
            ST_KD: begin
                a_op = {20'b0, i_job.vel_gain};
                b_op = {17'b0, i_cfg.hw_vel_gain};
            end
            ST_RATE: begin
                a_op = {i_job.vel_err[ANGLE_W+1], i_job.vel_err};
                b_op = {17'b0, i_cfg.inv_step};
            end
            ST_P: begin
                a_op = {{2{i_job.pos_err[ANGLE_W]}}, i_job.pos_err};
                b_op = {2'b0, r_kp};
            end
            ST_DLO: begin
                a_op = {10'b0, r_rate[RLO_W-1:0]};
                b_op = {2'b0, r_kd};
            end
            ST_DHI: begin
                a_op = {{10{r_rate[RATE_W-1]}}, r_rate[RATE_W-1:RLO_W]};
                b_op = {2'b0, r_kd};
            end
            // feedforward product is held while the result register is busy
            ST_FF, ST_OUT: begin
                a_op = {{3{i_job.trq_ref[ANGLE_W-1]}}, i_job.trq_ref};
                b_op = {18'b0, i_job.trq_gain};
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // floor of product / 256, and the high part of the split derivative product
    assign prod_shr = {{(ACC_W - P_W + 8){r_prod[P_W-1]}}, r_prod[P_W-1:8]};
    assign prod_hi  = {r_prod[ACC_W-RLO_W+7:0], {(RLO_W - 8){1'b0}}};

    always_comb begin
        n_acc = r_acc;
        case (r_step)
            ST_P:   n_acc = '0;
            ST_DLO: n_acc = r_acc + prod_shr;
            ST_DHI: n_acc = r_acc + prod_shr;
            ST_FF:  n_acc = r_acc + prod_hi;
            default: n_acc = r_acc;
        endcase
    end

    assign final_sum = r_acc + (i_job.ff_en ? prod_shr : '0);

    always_comb begin
        if (!final_sum[ACC_W-1] && (|final_sum[ACC_W-2:ANGLE_W-1])) begin
            sat_sum = {1'b0, {(ANGLE_W-1){1'b1}}};
        end else if (final_sum[ACC_W-1] && !(&final_sum[ACC_W-2:ANGLE_W-1])) begin
            sat_sum = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            sat_sum = final_sum[ANGLE_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_job_valid && (r_step == ST_OUT) && out_free;

    always_comb begin
        n_step = r_step;
        if (i_job_valid) begin
            if (r_step != ST_OUT) begin
                n_step = r_step + 1'b1;
            end else if (out_free) begin
                n_step = ST_KP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_KP;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= a_op * b_op;
        r_acc  <= n_acc;
        if (r_step == ST_KD) begin
            r_kp <= r_prod[K_W-1:0];
        end
        if (r_step == ST_RATE) begin
            r_kd <= r_prod[K_W-1:0];
        end
        if (r_step == ST_P) begin
            r_rate <= r_prod[RATE_W-1:0];
        end
        if (o_pop) begin
            r_out_joint  <= i_job.joint;
            r_out_torque <= i_job.active ? sat_sum : '0;
            r_out_servo  <= i_job.power_on;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_joint_out    = r_out_joint;
    assign o_drive_torque = r_out_torque;
    assign o_servo_is_on  = r_out_servo;

    a_step_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != ST_KP) |-> i_job_valid)
        else $error("sequencer running without a job");

    a_off_no_torque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_servo_is_on) |-> (o_drive_torque == '0))
        else $error("torque driven while servo off");

    a_pop_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_valid && (r_step == ST_KP)))
        else $error("finished job did not reach result register");

endmodule
`default_nettype wire
